>>> sv/rqr_pkg.sv
`default_nettype none

package rqr_pkg;

  localparam int MAX_PROCS = 32;
  localparam int ID_W      = 5;
  // id 0 is the idle id and never sits in the queue
  localparam int NUM_CELLS = MAX_PROCS - 1;
  localparam int CNT_W     = $clog2(MAX_PROCS);

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] idx_t;
  typedef logic [1:0]       op_t;

  localparam op_t OP_ENQ = 2'd0;
  localparam op_t OP_DEQ = 2'd1;
  localparam op_t OP_REM = 2'd2;

  typedef logic [1:0] act_t;

  localparam act_t ACT_HOLD   = 2'd0;
  localparam act_t ACT_APPEND = 2'd1;
  localparam act_t ACT_SHIFT  = 2'd2;

  typedef struct packed {
    act_t act;
    idx_t pos;
    id_t  new_id;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/rqr_req_if.sv
`default_nettype none

interface rqr_req_if;
  import rqr_pkg::*;

  logic valid;
  logic ready;
  op_t  operation;
  id_t  process_id;

  modport source (output valid, output operation, output process_id, input ready);
  modport sink (input valid, input operation, input process_id, output ready);

endinterface

`default_nettype wire

>>> sv/rqr_rsp_if.sv
`default_nettype none

interface rqr_rsp_if;
  import rqr_pkg::*;

  logic valid;
  logic ready;
  id_t  dequeued_id;
  logic took_effect;
  logic queue_empty;

  modport source (output valid, output dequeued_id, output took_effect, output queue_empty,
                  input ready);
  modport sink (input valid, input dequeued_id, input took_effect, input queue_empty,
                output ready);

endinterface

`default_nettype wire

>>> sv/rqr_cell.sv
`default_nettype none

module rqr_cell (
  input  logic              clk,
  input  logic              rst,
  input  rqr_pkg::idx_t     idx,
  input  rqr_pkg::cell_ctl_t ctl,
  input  rqr_pkg::id_t      probe_id,
  input  logic              right_valid,
  input  rqr_pkg::id_t      right_id,
  output logic              valid,
  output rqr_pkg::id_t      id,
  output logic              match
);
  import rqr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.act)
        ACT_APPEND: begin
          if (idx == ctl.pos) valid <= 1'b1;
        end
        ACT_SHIFT: begin
          // every cell from the removed slot on takes its right neighbor
          if (idx >= ctl.pos) valid <= right_valid;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_APPEND: begin
        if (idx == ctl.pos) id <= ctl.new_id;
      end
      ACT_SHIFT: begin
        if (idx >= ctl.pos) id <= right_id;
      end
      default: ;
    endcase
  end

  assign match = valid && (id == probe_id);

endmodule

`default_nettype wire

>>> sv/ready_queue_with_removal.sv
// FIFO ready queue of process ids with removal from any position.
// Requests arrive on req (operation, process_id): enqueue appends an id at
// the tail, dequeue pops the head, remove takes a queued id out wherever it
// sits. Every request gives exactly one response on rsp: dequeued_id (0 when
// nothing was popped), took_effect and queue_empty after the request.
// The ids live in a row of cells, head in cell 0; the queue stays packed
// toward cell 0 and a removal shifts every later cell one step to the left.
// In the accept cycle the id is compared against every cell and the slot is
// located; the decision is registered, and in the exec phase the row of cells
// shifts or loads and the response is written. req.ready is high whenever no
// request is in flight, so a new request waits until the last one is written.
// The response sits in an output register, so a new request can be taken
// while the previous response waits. When rsp stays stalled, the exec phase
// holds until the response register frees and req.ready stays low.
// Synchronous reset empties the queue and drops any pending response.
`default_nettype none

module ready_queue_with_removal (
  input logic      clk,
  input logic      rst,
  rqr_req_if.sink  req,
  rqr_rsp_if.source rsp
);
  import rqr_pkg::*;

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  logic                 phase;
  idx_t                 count;
  logic [MAX_PROCS-1:0] queued;

  logic                 chain_valid [NUM_CELLS+1];
  id_t                  chain_id    [NUM_CELLS+1];
  logic [NUM_CELLS-1:0] cell_match;
  cell_ctl_t            cell_ctl;

  cell_ctl_t ctl_d;
  id_t       popped_d;
  id_t       flag_id_d;
  idx_t      hit_pos;
  logic      id_ok;

  cell_ctl_t pend_ctl;
  id_t       pend_popped;
  id_t       pend_flag_id;

  logic      rsp_valid;
  id_t       out_id;
  logic      out_took;
  logic      out_empty;

  logic      req_fire;
  logic      commit;
  idx_t      count_after;

  assign req.ready = (phase == PH_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign commit    = (phase == PH_EXEC) && (!rsp_valid || rsp.ready);

  always_comb begin
    cell_ctl = pend_ctl;
    if (!commit) cell_ctl.act = ACT_HOLD;
  end

  // end of the row never holds an id
  assign chain_valid[NUM_CELLS] = 1'b0;
  assign chain_id[NUM_CELLS]    = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    rqr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (CNT_W'(g)),
      .ctl         (cell_ctl),
      .probe_id    (req.process_id),
      .right_valid (chain_valid[g+1]),
      .right_id    (chain_id[g+1]),
      .valid       (chain_valid[g]),
      .id          (chain_id[g]),
      .match       (cell_match[g])
    );
  end

  // an id sits in at most one cell, so or-ing the indexes encodes the hit
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (cell_match[i]) hit_pos = hit_pos | CNT_W'(i);
    end
  end

  assign id_ok = (req.process_id != '0) && (32'(req.process_id) < MAX_PROCS);

  always_comb begin
    ctl_d.act    = ACT_HOLD;
    ctl_d.pos    = count;
    ctl_d.new_id = req.process_id;
    popped_d     = '0;
    flag_id_d    = req.process_id;
    case (req.operation)
      OP_ENQ: begin
        if (id_ok && !queued[req.process_id]) ctl_d.act = ACT_APPEND;
      end
      OP_DEQ: begin
        if (chain_valid[0]) begin
          ctl_d.act = ACT_SHIFT;
          ctl_d.pos = '0;
          popped_d  = chain_id[0];
          flag_id_d = chain_id[0];
        end
      end
      OP_REM: begin
        if (id_ok && queued[req.process_id]) begin
          ctl_d.act = ACT_SHIFT;
          ctl_d.pos = hit_pos;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (pend_ctl.act)
      ACT_APPEND: count_after = count + idx_t'(1);
      ACT_SHIFT:  count_after = count - idx_t'(1);
      default:    count_after = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      pend_ctl     <= ctl_d;
      pend_popped  <= popped_d;
      pend_flag_id <= flag_id_d;
    end
    if (commit) begin
      out_id    <= pend_popped;
      out_took  <= (pend_ctl.act != ACT_HOLD);
      out_empty <= (count_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      queued    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) phase <= PH_EXEC;
      if (commit) begin
        phase     <= PH_IDLE;
        count     <= count_after;
        rsp_valid <= 1'b1;
        case (pend_ctl.act)
          ACT_APPEND: queued[pend_flag_id] <= 1'b1;
          ACT_SHIFT:  queued[pend_flag_id] <= 1'b0;
          default: ;
        endcase
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.dequeued_id = out_id;
  assign rsp.took_effect = out_took;
  assign rsp.queue_empty = out_empty;

endmodule

`default_nettype wire

>>> sv/rqr_checker.sv
`default_nettype none

module rqr_checker (
  input logic         clk,
  input logic         rst,
  input logic         req_valid,
  input logic         req_ready,
  input logic         rsp_valid,
  input logic         rsp_ready,
  input rqr_pkg::id_t rsp_dequeued_id,
  input logic         rsp_took_effect,
  input logic         rsp_queue_empty
);
  import rqr_pkg::*;

  logic req_fire;

  assign req_fire = req_valid && req_ready;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("request taken while another is in flight");

  // a fresh response always traces back to an accepted request
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_fire, 2))
    else $error("response appeared without a request two cycles before");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dequeued_id)
      && $stable(rsp_took_effect) && $stable(rsp_queue_empty))
    else $error("stalled response changed");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid && req_ready)
    else $error("block not idle after reset");

endmodule

bind ready_queue_with_removal rqr_checker u_rqr_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_dequeued_id (rsp.dequeued_id),
  .rsp_took_effect (rsp.took_effect),
  .rsp_queue_empty (rsp.queue_empty)
);

`default_nettype wire

>>> tb/sv/rqr_queue_check.sv
`timescale 1ns / 100ps

module rqr_queue_check (
  input  logic      clk,
  input  logic      rst,
  rqr_req_if        req,
  rqr_rsp_if        rsp,
  output int        fails,
  output int        pending
);
  import rqr_pkg::*;

  typedef struct packed {
    id_t  dequeued_id;
    logic took_effect;
    logic queue_empty;
  } queue_rsp_t;

  // shadow of the ready queue: ids in order, head first
  id_t                  queue_order[$];
  logic [MAX_PROCS-1:0] is_queued;
  queue_rsp_t           rsp_expected[$];

  function automatic queue_rsp_t apply_request(op_t op, id_t pid);
    queue_rsp_t r;
    int         pos;
    r   = '0;
    pos = 0;
    case (op)
      OP_ENQ: begin
        // idle id and ids already queued are dropped
        if (pid != '0 && !is_queued[pid]) begin
          queue_order.push_back(pid);
          is_queued[pid] = 1'b1;
          r.took_effect  = 1'b1;
        end
      end
      OP_DEQ: begin
        if (queue_order.size() != 0) begin
          r.dequeued_id = queue_order.pop_front();
          is_queued[r.dequeued_id] = 1'b0;
          r.took_effect = 1'b1;
        end
      end
      OP_REM: begin
        if (is_queued[pid]) begin
          foreach (queue_order[i])
            if (queue_order[i] == pid) pos = i;
          queue_order.delete(pos);
          is_queued[pid] = 1'b0;
          r.took_effect  = 1'b1;
        end
      end
      default: ;
    endcase
    r.queue_empty = (queue_order.size() == 0);
    return r;
  endfunction

  initial fails = 0;

  always @(posedge clk) begin
    queue_rsp_t exp_rsp;
    int         errs;
    errs = 0;
    if (rst) begin
      queue_order.delete();
      rsp_expected.delete();
      is_queued = '0;
    end else begin
      if (req.valid && req.ready)
        rsp_expected.push_back(apply_request(req.operation, req.process_id));
      if (rsp.valid && rsp.ready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: response with no request pending: dequeued_id %0d took_effect %0b",
                   $time, rsp.dequeued_id, rsp.took_effect);
          errs++;
        end else begin
          exp_rsp = rsp_expected.pop_front();
          if (rsp.dequeued_id !== exp_rsp.dequeued_id) begin
            $display("%0t: dequeued_id expected %0d actual %0d",
                     $time, exp_rsp.dequeued_id, rsp.dequeued_id);
            errs++;
          end
          if (rsp.took_effect !== exp_rsp.took_effect) begin
            $display("%0t: took_effect expected %0b actual %0b",
                     $time, exp_rsp.took_effect, rsp.took_effect);
            errs++;
          end
          if (rsp.queue_empty !== exp_rsp.queue_empty) begin
            $display("%0t: queue_empty expected %0b actual %0b",
                     $time, exp_rsp.queue_empty, rsp.queue_empty);
            errs++;
          end
        end
      end
      if (errs != 0) fails <= fails + errs;
    end
    pending = rsp_expected.size();
  end

endmodule

>>> tb/sv/tb_ready_queue_with_removal.sv
`timescale 1ns / 100ps

module tb_ready_queue_with_removal;
  import rqr_pkg::*;

  localparam op_t OP_UNUSED  = 2'd3;
  localparam int  STALL_LIMIT = 2000;
  localparam int  CHUNKS      = 37;
  localparam int  CHUNK_LEN   = 50;

  logic clk;
  logic rst;
  logic calm;
  int   fail_count;
  int   open_count;
  int   stall_cycles;

  rqr_req_if req_ch ();
  rqr_rsp_if rsp_ch ();

  ready_queue_with_removal uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rqr_queue_check chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .fails   (fail_count),
    .pending (open_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst)
      rsp_ch.ready <= 1'b0;
    else
      rsp_ch.ready <= calm || ($urandom_range(99) >= 35);
  end

  // cycles in a row with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    @(negedge rst);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(op_t op, id_t pid);
    while (!calm && $urandom_range(99) < 35) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.process_id <= pid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic random_request(int enq_pct, int deq_pct, int rem_pct);
    int  pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < enq_pct)
      op = OP_ENQ;
    else if (pick < enq_pct + deq_pct)
      op = OP_DEQ;
    else if (pick < enq_pct + deq_pct + rem_pct)
      op = OP_REM;
    else
      op = OP_UNUSED;
    send_request(op, id_t'($urandom_range(31)));
  endtask

  initial begin
    id_t order[MAX_PROCS-1];
    id_t tmp;
    int  j;
    int  kind;
    rst  = 1'b1;
    calm <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_ENQ;
    req_ch.process_id <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty, idle id, duplicates, removal at head, middle, tail
    send_request(OP_DEQ, 5'd7);
    send_request(OP_REM, 5'd0);
    send_request(OP_ENQ, 5'd0);
    send_request(OP_UNUSED, 5'd31);
    send_request(OP_ENQ, 5'd1);
    send_request(OP_ENQ, 5'd1);
    send_request(OP_ENQ, 5'd31);
    send_request(OP_ENQ, 5'd16);
    send_request(OP_ENQ, 5'd2);
    send_request(OP_REM, 5'd16);
    send_request(OP_REM, 5'd5);
    send_request(OP_REM, 5'd2);
    send_request(OP_UNUSED, 5'd0);
    send_request(OP_REM, 5'd1);
    send_request(OP_ENQ, 5'd30);
    send_request(OP_ENQ, 5'd1);
    send_request(OP_DEQ, 5'd31);
    send_request(OP_DEQ, 5'd0);
    send_request(OP_REM, 5'd1);
    send_request(OP_REM, 5'd1);
    send_request(OP_DEQ, 5'd0);
    send_request(OP_ENQ, 5'd31);
    send_request(OP_REM, 5'd31);

    for (int c = 0; c < CHUNKS; c++) begin
      calm <= (c >= 12 && c < 18);
      if (c % 9 == 4) begin
        // fill the whole queue in shuffled order, then take it apart
        for (int i = 0; i < MAX_PROCS - 1; i++) order[i] = id_t'(i + 1);
        for (int i = MAX_PROCS - 2; i > 0; i--) begin
          j        = $urandom_range(i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        foreach (order[i]) send_request(OP_ENQ, order[i]);
        for (int i = MAX_PROCS - 1; i < CHUNK_LEN; i++)
          random_request(5, 35, 58);
      end else begin
        kind = $urandom_range(2);
        for (int i = 0; i < CHUNK_LEN; i++) begin
          case (kind)
            0:       random_request(60, 20, 15);
            1:       random_request(20, 35, 40);
            default: random_request(40, 30, 25);
          endcase
        end
      end
    end

    // drain whatever is left
    calm <= 1'b0;
    for (int i = 0; i < MAX_PROCS; i++) send_request(OP_DEQ, id_t'($urandom_range(31)));
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (open_count != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && open_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
sv/rqr_pkg.sv
sv/rqr_req_if.sv
sv/rqr_rsp_if.sv
sv/rqr_cell.sv
sv/ready_queue_with_removal.sv
sv/rqr_checker.sv
tb/sv/rqr_queue_check.sv
tb/sv/tb_ready_queue_with_removal.sv
